// File: sv/mlfq_pkg.sv
// Shared types, constants and codes of the multilevel feedback queue scheduler.
package mlfq_pkg;

  localparam int unsigned LevelsDefault     = 8;
  localparam int unsigned TableDepthDefault = 64;
  localparam logic [15:0] QuantumReset      = 16'd10;

  typedef enum logic [1:0] {
    CMD_SUBMIT    = 2'd0,
    CMD_DISPATCH  = 2'd1,
    CMD_TERMINATE = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_SUBMITTED  = 3'd0,
    ST_DEMOTED    = 3'd1,
    ST_FINISHED   = 3'd2,
    ST_IDLE       = 3'd3,
    ST_TERMINATED = 3'd4,
    ST_NOT_FOUND  = 3'd5,
    ST_FULL       = 3'd6
  } status_e;

  // One accepted command on its way from the front end to the engine.
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] id;
    logic [15:0] len;
  } cmd_t;

  typedef enum logic [3:0] {
    EN_IDLE,
    EN_SUB_WR,
    EN_SUB_LINK,
    EN_DSP_FIND,
    EN_DSP_RD,
    EN_DSP_EVAL,
    EN_DSP_LINK,
    EN_TRM_LVL,
    EN_TRM_RD,
    EN_TRM_CMP,
    EN_TRM_UNLINK,
    EN_DONE
  } engine_e;

endpackage

// File: sv/mlfq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mlfq_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/mlfq_front.sv
// Front end: takes commands, drops unknown codes and feeds a short queue.
module mlfq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [1:0]      command_i,
  input  logic [15:0]     task_id_i,
  input  logic [15:0]     task_length_i,
  output logic            busy_o,
  output logic            q_valid_o,
  output mlfq_pkg::cmd_t  q_data_o,
  input  logic            q_pop_i
);
  import mlfq_pkg::*;

  // Two-entry queue.
  cmd_t       buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push;

  assign busy_o    = (cnt_q == 2'd2);
  assign push      = start_i && !busy_o && (cmd_e'(command_i) != CMD_NONE);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = buf_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= !wr_q;
      end
      if (q_pop_i) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= '{cmd: cmd_e'(command_i), id: task_id_i, len: task_length_i};
    end
  end

endmodule

// File: sv/mlfq_engine.sv
// Back end: walks the task table and level lists to carry out one command.
module mlfq_engine #(
  parameter int unsigned Levels     = mlfq_pkg::LevelsDefault,
  parameter int unsigned TableDepth = mlfq_pkg::TableDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  mlfq_pkg::cmd_t q_data_i,
  output logic           q_pop_o,
  input  logic [15:0]    quantum_i,
  output logic           result_valid_o,
  output logic [2:0]     status_o,
  output logic [15:0]    result_id_o,
  output logic [2:0]     from_level_o,
  output logic [2:0]     to_level_o,
  output logic [15:0]    units_run_o
);
  import mlfq_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned LW = $clog2(Levels);
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned RW = 16 + 16 + 16 + AW;

  engine_e st_q, st_d;
  cmd_t    cmd_q, cmd_d;

  logic [TableDepth-1:0] used_q, used_d;
  logic [AW-1:0] head_q [Levels];
  logic [AW-1:0] tail_q [Levels];
  logic [CW-1:0] count_q [Levels];
  logic [AW-1:0] head_d [Levels];
  logic [AW-1:0] tail_d [Levels];
  logic [CW-1:0] count_d [Levels];

  logic [LW-1:0] lvl_q, lvl_d;
  logic [AW-1:0] ent_q, ent_d, prev_q, prev_d;
  logic [CW-1:0] k_q, k_d;

  logic [2:0]  o_st_q, o_st_d;
  logic [15:0] o_id_q, o_id_d, o_un_q, o_un_d;
  logic [2:0]  o_fr_q, o_fr_d, o_to_q, o_to_d;
  logic        o_v_q, o_v_d;

  // Table RAM: id, length, done, next packed per entry.
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;
  logic [15:0]   r_id, r_len, r_done;
  logic [AW-1:0] r_next;

  assign {r_id, r_len, r_done, r_next} = rdata;

  mlfq_ram #(.Width(RW), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Next-link patching without a second write port: we hold the entry fields
  // read earlier, so only whole-entry writes are needed.
  logic [RW-1:0] held_q, held_d;

  logic          free_found;
  logic [AW-1:0] free_idx;
  logic          lvl_found;
  logic [LW-1:0] lvl_first;
  logic [16:0]   remaining;
  logic [LW-1:0] to_lvl;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
    lvl_found = 1'b0;
    lvl_first = '0;
    for (int l = Levels - 1; l >= 0; l--) begin
      if (count_q[l] != '0) begin
        lvl_found = 1'b1;
        lvl_first = LW'(l);
      end
    end
  end

  assign remaining = (r_len > r_done) ? ({1'b0, r_len} - {1'b0, r_done}) : 17'd0;
  assign to_lvl    = (32'(lvl_q) + 1 < Levels) ? lvl_q + LW'(1) : lvl_q;

  always_comb begin
    st_d   = st_q;
    cmd_d  = cmd_q;
    used_d = used_q;
    head_d = head_q;
    tail_d = tail_q;
    count_d = count_q;
    lvl_d  = lvl_q;
    ent_d  = ent_q;
    prev_d = prev_q;
    k_d    = k_q;
    held_d = held_q;
    o_st_d = o_st_q;
    o_id_d = o_id_q;
    o_fr_d = o_fr_q;
    o_to_d = o_to_q;
    o_un_d = o_un_q;
    o_v_d  = 1'b0;
    q_pop_o = 1'b0;
    we     = 1'b0;
    waddr  = ent_q;
    wdata  = held_q;
    raddr  = ent_q;

    unique case (st_q)
      EN_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_data_i;
          o_id_d  = q_data_i.id;
          o_fr_d  = '0;
          o_to_d  = '0;
          o_un_d  = '0;
          unique case (q_data_i.cmd)
            CMD_SUBMIT: begin
              if (!free_found) begin
                o_st_d = ST_FULL;
                st_d   = EN_DONE;
              end else begin
                ent_d = free_idx;
                st_d  = EN_SUB_WR;
              end
            end
            CMD_DISPATCH: begin
              if (!lvl_found) begin
                o_st_d = ST_IDLE;
                o_id_d = '0;
                st_d   = EN_DONE;
              end else begin
                lvl_d = lvl_first;
                ent_d = head_q[lvl_first];
                st_d  = EN_DSP_RD;
              end
            end
            CMD_TERMINATE: begin
              lvl_d = '0;
              st_d  = EN_TRM_LVL;
            end
            default: st_d = EN_IDLE;
          endcase
        end
      end

      EN_SUB_WR: begin
        we     = 1'b1;
        waddr  = ent_q;
        wdata  = {cmd_q.id, cmd_q.len, 16'd0, AW'(0)};
        used_d[ent_q] = 1'b1;
        if (count_q[0] == '0) begin
          head_d[0] = ent_q;
          st_d = EN_DONE;
        end else begin
          raddr = tail_q[0];
          st_d  = EN_SUB_LINK;
        end
        tail_d[0]  = ent_q;
        count_d[0] = count_q[0] + CW'(1);
        o_st_d = ST_SUBMITTED;
      end

      EN_SUB_LINK: begin
        // rdata holds the old tail; point it to the new entry.
        we    = 1'b1;
        waddr = prev_q;
        wdata = {r_id, r_len, r_done, ent_q};
        st_d  = EN_DONE;
      end

      EN_DSP_RD: begin
        raddr = ent_q;
        st_d  = EN_DSP_EVAL;
      end

      EN_DSP_EVAL: begin
        count_d[lvl_q] = count_q[lvl_q] - CW'(1);
        head_d[lvl_q]  = r_next;
        o_id_d = r_id;
        o_fr_d = 3'(lvl_q);
        if (quantum_i != 16'd0 && remaining <= {1'b0, quantum_i}) begin
          o_un_d = (remaining == 17'd0) ? 16'd1 : remaining[15:0];
          o_st_d = ST_FINISHED;
          used_d[ent_q] = 1'b0;
          st_d = EN_DONE;
        end else begin
          o_un_d = quantum_i;
          o_st_d = ST_DEMOTED;
          o_to_d = 3'(to_lvl);
          we    = 1'b1;
          waddr = ent_q;
          wdata = {r_id, r_len, r_done + quantum_i, AW'(0)};
          // Count after the pop above, since to_lvl may equal lvl_q.
          if (to_lvl == lvl_q ? (count_q[lvl_q] == CW'(1)) : (count_q[to_lvl] == '0)) begin
            head_d[to_lvl] = ent_q;
            st_d = EN_DONE;
          end else begin
            raddr = tail_q[to_lvl];
            st_d  = EN_DSP_LINK;
          end
          prev_d = tail_q[to_lvl];
          tail_d[to_lvl] = ent_q;
          count_d[to_lvl] = (to_lvl == lvl_q) ? count_q[lvl_q] : count_q[to_lvl] + CW'(1);
        end
      end

      EN_DSP_LINK: begin
        we    = 1'b1;
        waddr = prev_q;
        wdata = {r_id, r_len, r_done, ent_q};
        st_d  = EN_DONE;
      end

      EN_TRM_LVL: begin
        ent_d  = head_q[lvl_q];
        prev_d = '0;
        k_d    = '0;
        if (count_q[lvl_q] == '0) begin
          if (32'(lvl_q) + 1 >= Levels) begin
            o_st_d = ST_NOT_FOUND;
            st_d   = EN_DONE;
          end else begin
            lvl_d = lvl_q + LW'(1);
          end
        end else begin
          st_d = EN_TRM_RD;
        end
      end

      EN_TRM_RD: begin
        raddr = ent_q;
        st_d  = EN_TRM_CMP;
      end

      EN_TRM_CMP: begin
        if (used_q[ent_q] && r_id == cmd_q.id) begin
          if (k_q == '0) begin
            head_d[lvl_q] = r_next;
          end
          if (k_q + CW'(1) == count_q[lvl_q]) begin
            tail_d[lvl_q] = prev_q;
          end
          count_d[lvl_q] = count_q[lvl_q] - CW'(1);
          used_d[ent_q]  = 1'b0;
          o_st_d = ST_TERMINATED;
          o_fr_d = 3'(lvl_q);
          if (k_q == '0) begin
            st_d = EN_DONE;
          end else begin
            held_d = {16'd0, 16'd0, 16'd0, r_next};
            raddr  = prev_q;
            st_d   = EN_TRM_UNLINK;
          end
        end else if (k_q + CW'(1) == count_q[lvl_q]) begin
          if (32'(lvl_q) + 1 >= Levels) begin
            o_st_d = ST_NOT_FOUND;
            st_d   = EN_DONE;
          end else begin
            lvl_d = lvl_q + LW'(1);
            st_d  = EN_TRM_LVL;
          end
        end else begin
          prev_d = ent_q;
          ent_d  = r_next;
          k_d    = k_q + CW'(1);
          st_d   = EN_TRM_RD;
        end
      end

      EN_TRM_UNLINK: begin
        // rdata holds the predecessor; bypass the removed entry.
        we    = 1'b1;
        waddr = prev_q;
        wdata = {r_id, r_len, r_done, held_q[AW-1:0]};
        st_d  = EN_DONE;
      end

      EN_DONE: begin
        o_v_d = 1'b1;
        st_d  = EN_IDLE;
      end

      default: st_d = EN_IDLE;
    endcase

    // Submit link reads the old tail, kept in prev.
    if (st_q == EN_SUB_WR) begin
      prev_d = tail_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= EN_IDLE;
      used_q <= '0;
      o_v_q  <= 1'b0;
      for (int l = 0; l < Levels; l++) begin
        head_q[l]  <= '0;
        tail_q[l]  <= '0;
        count_q[l] <= '0;
      end
    end else begin
      st_q    <= st_d;
      used_q  <= used_d;
      o_v_q   <= o_v_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    lvl_q  <= lvl_d;
    ent_q  <= ent_d;
    prev_q <= prev_d;
    k_q    <= k_d;
    held_q <= held_d;
    o_st_q <= o_st_d;
    o_id_q <= o_id_d;
    o_fr_q <= o_fr_d;
    o_to_q <= o_to_d;
    o_un_q <= o_un_d;
  end

  assign result_valid_o = o_v_q;
  assign status_o       = o_st_q;
  assign result_id_o    = o_id_q;
  assign from_level_o   = o_fr_q;
  assign to_level_o     = o_to_q;
  assign units_run_o    = o_un_q;

endmodule

// File: sv/multilevel_feedback_queue_scheduler.sv
// Top level of the multilevel feedback queue scheduler.
//
// Commands arrive on start_i with command_i, task_id_i and task_length_i; a
// transaction is taken on a rising edge where start_i is high and busy_o is
// low. Submit (0) appends a task to level 0, dispatch (1) runs the head of
// the highest-priority non-empty level for one quantum, terminate (2)
// removes the first task with a matching id. Code 3 is dropped silently.
// A front end queues up to two commands so that the engine can run alone.
// Each command gives one result, shown for exactly one cycle while
// result_valid_o is high; the receiver cannot stall it.
// Submit runs EN_SUB_WR, then EN_SUB_LINK if level 0 was not empty;
// dispatch runs EN_DSP_RD and EN_DSP_EVAL, then EN_DSP_LINK when the
// demoted task joins a non-empty level. Terminate runs EN_TRM_LVL for
// each level it searches, EN_TRM_RD and EN_TRM_CMP for each entry it
// compares, and EN_TRM_UNLINK when the match is not a level head.
// The user must write the quantum register over cfg_valid_i/cfg_ready_i only while idle; the block does not enforce it.
// Reset empties all levels, frees the table and sets the quantum to 10.
module multilevel_feedback_queue_scheduler #(
  parameter int unsigned Levels     = mlfq_pkg::LevelsDefault,
  parameter int unsigned TableDepth = mlfq_pkg::TableDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] task_id_i,
  input  logic [15:0] task_length_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [15:0] result_id_o,
  output logic [2:0]  from_level_o,
  output logic [2:0]  to_level_o,
  output logic [15:0] units_run_o
);
  import mlfq_pkg::*;

  logic        q_valid, q_pop;
  cmd_t        q_data;
  logic [15:0] quantum_q;

  // The quantum register is always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QuantumReset;
    end else if (cfg_valid_i) begin
      quantum_q <= cfg_data_i;
    end
  end

  mlfq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .command_i    (command_i),
    .task_id_i    (task_id_i),
    .task_length_i(task_length_i),
    .busy_o       (busy_o),
    .q_valid_o    (q_valid),
    .q_data_o     (q_data),
    .q_pop_i      (q_pop)
  );

  mlfq_engine #(.Levels(Levels), .TableDepth(TableDepth)) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .quantum_i     (quantum_q),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .result_id_o   (result_id_o),
    .from_level_o  (from_level_o),
    .to_level_o    (to_level_o),
    .units_run_o   (units_run_o)
  );

endmodule
